/* rtl/core/vma_pkg.sv */
// Shared types and constants for the vector moving average block.
// Used by vector_moving_average and vma_mean_sat; depends on nothing.
package vma_pkg;

   localparam int NUM_FIELDS = 4;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 24;
   localparam int LEN_REG_W  = 7;
   localparam int RECIP_W    = 17;
   localparam int FRAC_W     = 16;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam int WINDOW_MAX_DEFAULT = 64;
   localparam int LANES_DEFAULT      = 4;

   localparam logic [LEN_REG_W-1:0] WINDOW_LEN_RESET = LEN_REG_W'(8);
   localparam logic [RECIP_W-1:0]   RECIP_RESET      = RECIP_W'(8192);

   localparam int MEAN_MAX = 2 ** (SAMPLE_W - 1) - 1;
   localparam int MEAN_MIN = -(2 ** (SAMPLE_W - 1));

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_STEP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FILL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CORRECT = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP      = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] lane0_sample;
      logic signed [SAMPLE_W-1:0] lane1_sample;
      logic signed [SAMPLE_W-1:0] lane2_sample;
      logic signed [SAMPLE_W-1:0] lane3_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lane0_mean;
      logic signed [SAMPLE_W-1:0] lane1_mean;
      logic signed [SAMPLE_W-1:0] lane2_mean;
      logic signed [SAMPLE_W-1:0] lane3_mean;
   } rsp_type;

endpackage

/* rtl/core/vma_mean_sat.sv */
// One lane of the mean output: registered sum times reciprocal, then
// floor shift and saturation to the sample width. Depends on vma_pkg.
module vma_mean_sat (
   input  logic                          clock,
   input  logic [vma_pkg::SUM_W-1:0]     sum,
   input  logic [vma_pkg::RECIP_W-1:0]   recip,
   output logic [vma_pkg::SAMPLE_W-1:0]  mean
);
   import vma_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W + 1;
   localparam int Q_W    = PROD_W - FRAC_W;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(MEAN_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(MEAN_MIN);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [Q_W-1:0]    quotient;

   assign product_in = $signed(sum) * $signed({1'b0, recip});

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // Dropping the fraction bits of a two's complement value rounds toward
   // minus infinity.
   assign quotient = $signed(product_ff[PROD_W-1:FRAC_W]);

   always_comb begin
      priority if (quotient > Q_MAX) begin
         mean = Q_MAX[SAMPLE_W-1:0];
      end else if (quotient < Q_MIN) begin
         mean = Q_MIN[SAMPLE_W-1:0];
      end else begin
         mean = quotient[SAMPLE_W-1:0];
      end
   end

endmodule

/* rtl/core/vector_moving_average.sv */
// Top level of the vector moving average (boxcar) filter.
// Depends on vma_pkg and vma_mean_sat.
//
// Boxcar moving average over LANES signed 16-bit lanes. The delay line
// lives in one synchronous memory of WINDOW_MAX rows, one row per item,
// with a registered read. A step item passes through memory read, sum
// update and write back, multiply by recip, and the load of the output
// register, which waits on rsp_stall while the slot is full. Fill and
// correct items rewrite the whole delay line one row per cycle; an item
// of unused kind is accepted and gives no result. After reset a clearing
// pass zeroes every row of the memory, and no item is taken until it ends;
// configuration writes are taken at any time. The output register lets a
// new item be taken while the previous result waits on rsp_stall. Lanes
// at or above LANES return a mean of zero.
module vector_moving_average #(
   parameter int WINDOW_MAX = vma_pkg::WINDOW_MAX_DEFAULT,
   parameter int LANES      = vma_pkg::LANES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  vma_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vma_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vma_pkg::CSR_DATA_W-1:0]  csr_data
);
   import vma_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int ROW_W  = LANES * SAMPLE_W;
   localparam int MULT_W = SUM_W + LEN_W + 1;
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(WINDOW_MAX - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] ST_SWEEP = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [KIND_W-1:0]      kind_ff;
   logic [SAMPLE_W-1:0]    v_ff [LANES];
   logic [SUM_W-1:0]       running_ff [LANES];
   logic [SUM_W-1:0]       running_in [LANES];
   logic [SUM_W-1:0]       direct_ff [LANES];
   logic [SUM_W-1:0]       direct_in [LANES];
   logic [LEN_REG_W-1:0]   window_len_ff;
   logic [RECIP_W-1:0]     recip_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic [ROW_W-1:0]       mem [WINDOW_MAX];
   logic [ROW_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ROW_W-1:0]       wr_data;

   logic                   req_fire;
   logic                   rsp_load;
   logic [LEN_W-1:0]       eff_len;
   logic [LEN_W-1:0]       idx_next;
   logic                   wrap;
   logic [SAMPLE_W-1:0]    v_in [NUM_FIELDS];
   logic [SAMPLE_W-1:0]    mean_lane [NUM_FIELDS];

   assign v_in[0] = req_data.lane0_sample;
   assign v_in[1] = req_data.lane1_sample;
   assign v_in[2] = req_data.lane2_sample;
   assign v_in[3] = req_data.lane3_sample;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         recip_ff      <= RECIP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: window_len_ff <= csr_data[LEN_REG_W-1:0];
            CSR_RECIP:      recip_ff      <= csr_data[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one, a length above the store depth as the
   // full depth.
   always_comb begin
      priority if (window_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(window_len_ff) > WINDOW_MAX) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = LEN_W'(window_len_ff);
      end
   end

   assign idx_next = LEN_W'(idx_ff) + LEN_W'(1);
   assign wrap     = (idx_next >= eff_len);

   // Read address: a step reads its own row, a sweep reads one row ahead of
   // the row it writes.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = (req_data.kind == KIND_STEP) ? idx_ff : '0;
      end else begin
         rd_addr = (cnt_ff == LAST_ROW) ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Write port and sum updates.
   always_comb begin
      logic signed [MULT_W-1:0] len_prod;
      logic signed [MULT_W-1:0] idx_prod;
      logic [SUM_W-1:0]         v_ext;
      logic [SUM_W-1:0]         old_ext;
      logic [SUM_W-1:0]         direct_step;
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      for (int l = 0; l < LANES; l++) begin
         running_in[l] = running_ff[l];
         direct_in[l]  = direct_ff[l];
      end
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_STEP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            for (int l = 0; l < LANES; l++) begin
               v_ext       = SUM_W'($signed(v_ff[l]));
               old_ext     = SUM_W'($signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]));
               direct_step = direct_ff[l] + v_ext;
               wr_data[l*SAMPLE_W +: SAMPLE_W] = v_ff[l];
               if (wrap) begin
                  running_in[l] = direct_step;
                  direct_in[l]  = '0;
               end else begin
                  running_in[l] = running_ff[l] + v_ext - old_ext;
                  direct_in[l]  = direct_step;
               end
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            for (int l = 0; l < LANES; l++) begin
               len_prod = MULT_W'($signed(v_ff[l])) * $signed(MULT_W'({1'b0, eff_len}));
               idx_prod = MULT_W'($signed(v_ff[l])) * $signed(MULT_W'({1'b0, idx_ff}));
               if (kind_ff == KIND_FILL) begin
                  wr_data[l*SAMPLE_W +: SAMPLE_W] = v_ff[l];
               end else begin
                  wr_data[l*SAMPLE_W +: SAMPLE_W] =
                     rd_data_ff[l*SAMPLE_W +: SAMPLE_W] - v_ff[l];
               end
               // The sums change once, on the first row of the sweep.
               if (cnt_ff == '0) begin
                  if (kind_ff == KIND_FILL) begin
                     running_in[l] = len_prod[SUM_W-1:0];
                     direct_in[l]  = '0;
                  end else begin
                     running_in[l] = running_ff[l] - len_prod[SUM_W-1:0];
                     direct_in[l]  = direct_ff[l] - idx_prod[SUM_W-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               priority if (req_data.kind == KIND_STEP) begin
                  state_in = ST_STEP;
               end else if (req_data.kind == KIND_FILL ||
                            req_data.kind == KIND_CORRECT) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STEP: begin
            idx_in   = wrap ? '0 : idx_next[IDX_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_ROW) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
               if (kind_ff == KIND_FILL) begin
                  idx_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         for (int l = 0; l < LANES; l++) begin
            running_ff[l] <= '0;
            direct_ff[l]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         for (int l = 0; l < LANES; l++) begin
            running_ff[l] <= running_in[l];
            direct_ff[l]  <= direct_in[l];
         end
      end
   end

   // Item payload, held for the whole of its processing.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_data.kind;
         for (int l = 0; l < LANES; l++) begin
            v_ff[l] <= v_in[l];
         end
      end
   end

   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_lane
      if (g < LANES) begin : g_used
         vma_mean_sat u_mean (
            .clock (clock),
            .sum   (running_ff[g]),
            .recip (recip_ff),
            .mean  (mean_lane[g])
         );
      end else begin : g_unused
         assign mean_lane[g] = '0;
      end
   end

   // Output register: cleared when its transfer completes, reloaded when a
   // step result is ready and the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.lane0_mean <= mean_lane[0];
         rsp_data_ff.lane1_mean <= mean_lane[1];
         rsp_data_ff.lane2_mean <= mean_lane[2];
         rsp_data_ff.lane3_mean <= mean_lane[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
